>>> rtl/pbd_pkg.sv
`timescale 1ns / 1ps

package pbd_pkg;

  // Coordinate and angle formats.
  localparam int COORD_BITS      = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int BEARING_BITS    = 16;

  // The angle accumulator counts units of 2^-20 degree.
  localparam int ACC_FRAC    = 20;
  localparam int GUARD_SHIFT = 60 - COORD_BITS;
  localparam int TABLE_LEN   = 24;
  localparam int STEP_W      = $clog2(TABLE_LEN);

  // Vector datapath: magnitudes sit below bit 60 and the CORDIC gain stays under 2.4.
  localparam int CW = 64;
  // Angle accumulator: the sum of all table entries stays below 2^27.
  localparam int ZW = 32;

  // Rounding from accumulator units down to output fraction bits.
  localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

  // Widths of the quadrant angle and of the full bearing before masking.
  localparam int ANG_W = $clog2((90 << ANGLE_FRAC_BITS) + 1);
  localparam int BW    = $clog2((360 << ANGLE_FRAC_BITS) + 1);

  localparam logic [ANG_W-1:0] ANG_RIGHT = ANG_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [BW-1:0] DEG90  = BW'(90 << ANGLE_FRAC_BITS);
  localparam logic [BW-1:0] DEG180 = BW'(180 << ANGLE_FRAC_BITS);
  localparam logic [BW-1:0] DEG270 = BW'(270 << ANGLE_FRAC_BITS);
  localparam logic [BW-1:0] DEG360 = BW'(360 << ANGLE_FRAC_BITS);

  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(64'd1 << (RND_SHIFT - 1));
  localparam logic signed [ZW-1:0] RIGHT_Z    = ZW'(90 << ANGLE_FRAC_BITS);

  // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
  localparam logic signed [ZW-1:0] ATAN_UNITS [TABLE_LEN] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7
  };

  // Per-item information that travels beside the CORDIC vector.
  typedef struct packed {
    logic          special;      // axis or coincident case, bearing fixed
    logic          coincident;
    logic          dx_neg;
    logic          dy_neg;
    logic [BW-1:0] spec_bearing;
  } pbd_side_t;

endpackage

>>> rtl/pbd_cordic_stage.sv
`timescale 1ns / 1ps

module pbd_cordic_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [pbd_pkg::STEP_W-1:0]         step_i,
  input  logic                               valid_i,
  input  logic signed [pbd_pkg::CW-1:0]      x_i,
  input  logic signed [pbd_pkg::CW-1:0]      y_i,
  input  logic signed [pbd_pkg::ZW-1:0]      z_i,
  input  pbd_pkg::pbd_side_t                 side_i,
  output logic                               valid_o,
  output logic signed [pbd_pkg::CW-1:0]      x_o,
  output logic signed [pbd_pkg::CW-1:0]      y_o,
  output logic signed [pbd_pkg::ZW-1:0]      z_o,
  output pbd_pkg::pbd_side_t                 side_o
);

  logic signed [pbd_pkg::CW-1:0] xs;
  logic signed [pbd_pkg::CW-1:0] ys;
  logic signed [pbd_pkg::CW-1:0] x_d, x_q;
  logic signed [pbd_pkg::CW-1:0] y_d, y_q;
  logic signed [pbd_pkg::ZW-1:0] z_d, z_q;
  logic signed [pbd_pkg::ZW-1:0] atan_val;
  pbd_pkg::pbd_side_t            side_q;
  logic                          valid_q;

  // One vectoring rotation: drive y toward zero and accumulate the angle.
  always_comb begin
    xs       = x_i >>> step_i;
    ys       = y_i >>> step_i;
    atan_val = pbd_pkg::ATAN_UNITS[step_i];
    if (!y_i[pbd_pkg::CW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_val;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_val;
    end
  end

  // Valid bit of this stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload of this stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

>>> rtl/point_bearing_degrees.sv
`timescale 1ns / 1ps
// Bearing of a target point seen from a center point, 1/128 degree units.
// Pipeline: entry stage, one stage per CORDIC rotation, rounding, quadrant
// mapping, output register. Throughput: one item per cycle while in_stall_o
// is low; a two-entry output buffer absorbs stalls.
// Reset: asynchronous, active low, clears all valid bits; no clearing pass.
module point_bearing_degrees (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [pbd_pkg::COORD_BITS-1:0]   center_x_i,
  input  logic signed [pbd_pkg::COORD_BITS-1:0]   center_y_i,
  input  logic signed [pbd_pkg::COORD_BITS-1:0]   target_x_i,
  input  logic signed [pbd_pkg::COORD_BITS-1:0]   target_y_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [pbd_pkg::BEARING_BITS-1:0]        bearing_o,
  output logic                                    coincident_o
);

  localparam int N  = pbd_pkg::CORDIC_STEPS;
  localparam int CB = pbd_pkg::COORD_BITS;

  // Whole pipeline moves unless the output buffer is full.
  logic en;

  // Entry stage.
  logic signed [CB:0]        dx, dy;
  logic [CB:0]               adx, ady;
  pbd_pkg::pbd_side_t        side_d;
  logic                      ent_valid_q;
  logic [CB-1:0]             ax_q, ay_q;
  pbd_pkg::pbd_side_t        ent_side_q;

  // CORDIC chain.
  logic                          v_s    [N+1];
  logic signed [pbd_pkg::CW-1:0] x_s    [N+1];
  logic signed [pbd_pkg::CW-1:0] y_s    [N+1];
  logic signed [pbd_pkg::ZW-1:0] z_s    [N+1];
  pbd_pkg::pbd_side_t            side_s [N+1];

  // Rounding stage.
  logic signed [pbd_pkg::ZW-1:0] z_rnd;
  logic signed [pbd_pkg::ZW-1:0] a_s;
  logic [pbd_pkg::ANG_W-1:0]     ang_d, ang_q;
  logic                          rnd_valid_q;
  pbd_pkg::pbd_side_t            rnd_side_q;

  // Mapping stage.
  logic [pbd_pkg::BW-1:0]           ang_w;
  logic [pbd_pkg::BW-1:0]           b_raw, b_wrap;
  logic [pbd_pkg::BEARING_BITS-1:0] fin_bearing_d, fin_bearing_q;
  logic                             fin_coin_d, fin_coin_q;
  logic                             fin_valid_q;

  // Output register and skid entry.
  logic                             take, fin_go;
  logic                             out_valid_d, out_valid_q;
  logic                             skid_valid_d, skid_valid_q;
  logic [pbd_pkg::BEARING_BITS-1:0] out_bearing_d, out_bearing_q;
  logic [pbd_pkg::BEARING_BITS-1:0] skid_bearing_d, skid_bearing_q;
  logic                             out_coin_d, out_coin_q;
  logic                             skid_coin_d, skid_coin_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Offsets, magnitudes and the axis cases.
  always_comb begin
    dx  = $signed({target_x_i[CB-1], target_x_i}) - $signed({center_x_i[CB-1], center_x_i});
    dy  = $signed({target_y_i[CB-1], target_y_i}) - $signed({center_y_i[CB-1], center_y_i});
    adx = dx[CB] ? (CB+1)'(-dx) : dx;
    ady = dy[CB] ? (CB+1)'(-dy) : dy;
    side_d.dx_neg       = dx[CB];
    side_d.dy_neg       = dy[CB];
    side_d.coincident   = 1'b0;
    side_d.special      = 1'b0;
    side_d.spec_bearing = '0;
    if (dx == '0 && dy == '0) begin
      side_d.special    = 1'b1;
      side_d.coincident = 1'b1;
    end else if (dx == '0) begin
      side_d.special      = 1'b1;
      side_d.spec_bearing = dy[CB] ? pbd_pkg::DEG90 : pbd_pkg::DEG270;
    end else if (dy == '0) begin
      side_d.special      = 1'b1;
      side_d.spec_bearing = dx[CB] ? pbd_pkg::DEG180 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (en) begin
      ent_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q       <= adx[CB-1:0];
      ay_q       <= ady[CB-1:0];
      ent_side_q <= side_d;
    end
  end

  // Scale the magnitudes up into the CORDIC word.
  assign v_s[0]    = ent_valid_q;
  assign x_s[0]    = $signed({{(pbd_pkg::CW-CB){1'b0}}, ax_q}) <<< pbd_pkg::GUARD_SHIFT;
  assign y_s[0]    = $signed({{(pbd_pkg::CW-CB){1'b0}}, ay_q}) <<< pbd_pkg::GUARD_SHIFT;
  assign z_s[0]    = '0;
  assign side_s[0] = ent_side_q;

  // One registered stage per rotation.
  for (genvar i = 0; i < N; i++) begin : g_rot
    pbd_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (pbd_pkg::STEP_W'(i)),
      .valid_i (v_s[i]),
      .x_i     (x_s[i]),
      .y_i     (y_s[i]),
      .z_i     (z_s[i]),
      .side_i  (side_s[i]),
      .valid_o (v_s[i+1]),
      .x_o     (x_s[i+1]),
      .y_o     (y_s[i+1]),
      .z_o     (z_s[i+1]),
      .side_o  (side_s[i+1])
    );
  end

  // Round half up to the output fraction and clamp to 0..90 degrees.
  always_comb begin
    z_rnd = z_s[N] + pbd_pkg::ROUND_HALF;
    a_s   = z_rnd >>> pbd_pkg::RND_SHIFT;
    if (a_s[pbd_pkg::ZW-1]) begin
      ang_d = '0;
    end else if (a_s > pbd_pkg::RIGHT_Z) begin
      ang_d = pbd_pkg::ANG_RIGHT;
    end else begin
      ang_d = a_s[pbd_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
    end else if (en) begin
      rnd_valid_q <= v_s[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q      <= ang_d;
      rnd_side_q <= side_s[N];
    end
  end

  // Map the first-quadrant angle to the full turn.
  always_comb begin
    ang_w = pbd_pkg::BW'(ang_q);
    case ({rnd_side_q.dx_neg, rnd_side_q.dy_neg})
      2'b01:   b_raw = ang_w;
      2'b11:   b_raw = pbd_pkg::DEG180 - ang_w;
      2'b10:   b_raw = pbd_pkg::DEG180 + ang_w;
      default: b_raw = pbd_pkg::DEG360 - ang_w;
    endcase
    b_wrap = (b_raw >= pbd_pkg::DEG360) ? b_raw - pbd_pkg::DEG360 : b_raw;
    if (rnd_side_q.special) begin
      fin_bearing_d = pbd_pkg::BEARING_BITS'(rnd_side_q.spec_bearing);
    end else begin
      fin_bearing_d = pbd_pkg::BEARING_BITS'(b_wrap);
    end
    fin_coin_d = rnd_side_q.coincident;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en) begin
      fin_valid_q <= rnd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_bearing_q <= fin_bearing_d;
      fin_coin_q    <= fin_coin_d;
    end
  end

  // Output register with a skid entry that holds an item arriving while the output is stalled.
  always_comb begin
    take           = out_valid_q && !out_stall_i;
    fin_go         = fin_valid_q && en;
    out_valid_d    = out_valid_q;
    out_bearing_d  = out_bearing_q;
    out_coin_d     = out_coin_q;
    skid_valid_d   = skid_valid_q;
    skid_bearing_d = skid_bearing_q;
    skid_coin_d    = skid_coin_q;
    if (skid_valid_q) begin
      if (take) begin
        out_valid_d   = 1'b1;
        out_bearing_d = skid_bearing_q;
        out_coin_d    = skid_coin_q;
        skid_valid_d  = 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_d   = fin_go;
      out_bearing_d = fin_bearing_q;
      out_coin_d    = fin_coin_q;
    end else if (fin_go) begin
      skid_valid_d   = 1'b1;
      skid_bearing_d = fin_bearing_q;
      skid_coin_d    = fin_coin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bearing_q  <= out_bearing_d;
    out_coin_q     <= out_coin_d;
    skid_bearing_q <= skid_bearing_d;
    skid_coin_q    <= skid_coin_d;
  end

  assign out_valid_o  = out_valid_q;
  assign bearing_o    = out_bearing_q;
  assign coincident_o = out_coin_q;

`ifndef ASSERT_OFF
  // The skid entry is only used behind a held output item.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while output register is empty");

  // Coincident points always report a zero bearing.
  a_coin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && coincident_o) |-> (bearing_o == '0))
    else $error("coincident item with nonzero bearing");

  // The bearing stays below a full turn when the output width holds it.
  a_below_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((pbd_pkg::ANGLE_FRAC_BITS > 7) ||
                     (pbd_pkg::BW'(bearing_o) < pbd_pkg::DEG360)))
    else $error("bearing reached a full turn");

  // An item waiting in the skid entry moves out as soon as the output is taken.
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry did not drain after output was taken");
`endif

endmodule
